[rtl/gifs_pkg.sv]
// Shared types and constants for the GIF animation metadata scanner.
`default_nettype none
package gifs_pkg;

    localparam int unsigned WIN_DEPTH = 17;
    localparam int unsigned SCAN_LEN  = 18;
    localparam int unsigned CNT_W     = 5;

    localparam logic [CNT_W-1:0] SEEN_HDR_END = 5'd6;
    localparam logic [CNT_W-1:0] SEEN_GIF_MIN = 5'd5;
    localparam logic [CNT_W-1:0] SEEN_SCAN    = 5'd17;
    localparam logic [CNT_W-1:0] SEEN_MAX     = 5'd18;

    localparam logic [7:0] EXT_INTRO  = 8'h21;
    localparam logic [7:0] GCE_LABEL  = 8'hF9;
    localparam logic [7:0] GCE_SIZE   = 8'h04;
    localparam logic [7:0] APP_LABEL  = 8'hFF;
    localparam logic [7:0] APP_SIZE   = 8'h0B;
    localparam logic [7:0] SUB_LEN    = 8'h03;
    localparam logic [7:0] SUB_ID     = 8'h01;

    localparam int unsigned NAME_LEN = 11;
    localparam int unsigned NAME_POS = 3;

    localparam logic [7:0] NAME_A [0:NAME_LEN-1] = '{
        8'h4E, 8'h45, 8'h54, 8'h53, 8'h43, 8'h41, 8'h50, 8'h45, 8'h32, 8'h2E, 8'h30
    };
    localparam logic [7:0] NAME_B [0:NAME_LEN-1] = '{
        8'h41, 8'h4E, 8'h49, 8'h4D, 8'h45, 8'h58, 8'h54, 8'h53, 8'h31, 8'h2E, 8'h30
    };

    typedef struct packed {
        logic [7:0] data;
        logic       eq_a;
        logic       eq_b;
    } cell_out_t;

    // header byte check, GIF8?a with 7 or 9 at position four
    function automatic logic hdr_ok(input logic [2:0] pos, input logic [7:0] b);
        logic ok;
        case (pos)
            3'd0:    ok = (b == 8'h47);
            3'd1:    ok = (b == 8'h49);
            3'd2:    ok = (b == 8'h46);
            3'd3:    ok = (b == 8'h38);
            3'd4:    ok = (b == 8'h37) || (b == 8'h39);
            3'd5:    ok = (b == 8'h61);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage
`default_nettype wire

[rtl/gif_animation_metadata_scan.sv]
// Top level: GIF header check, sliding window scan and result register.
// Result: m_tvalid rises in the cycle after the final byte is accepted.
// Throughput: one byte per cycle; the 17-cell window chain and its compares decide
// every byte in the cycle it is accepted, so input is only held while a result waits.
// Reset: rst_n clears the window, counters and found values and drops m_tvalid;
// the window, counters and found values are cleared after each final byte, starting a new file.
`default_nettype none
module gif_animation_metadata_scan (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // frame_delay[19:0], loop_total[35:20], zero pad
    output logic             m_tuser    // is_gif
);
    import gifs_pkg::*;

    cell_out_t  cells [0:WIN_DEPTH-1];
    logic [7:0] full_w [0:SCAN_LEN-1];

    logic             accept;
    logic             done;
    logic [CNT_W-1:0] seen_reg,  seen_next;
    logic             hm_reg,    hm_next;
    logic [19:0]      delay_reg, delay_next;
    logic [15:0]      loops_reg, loops_next;
    logic             mv_reg,    mv_next;
    logic             gif_reg;
    logic [19:0]      odelay_reg;
    logic [15:0]      oloops_reg;
    logic             gce_hit, app_hit, name_a_hit, name_b_hit, scan_en, gif_now;
    logic [19:0]      cs_ext, cs_ms;

    assign s_tready = !mv_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign done     = accept && s_tlast;

    genvar k;
    generate
        for (k = 0; k < WIN_DEPTH; k++)
        begin : g_cell
            localparam logic [7:0] CA = (k >= NAME_POS && k < NAME_POS + NAME_LEN) ?
                                        NAME_A[(k >= NAME_POS && k < NAME_POS + NAME_LEN)
                                               ? k - NAME_POS : 0] : 8'h00;
            localparam logic [7:0] CB = (k >= NAME_POS && k < NAME_POS + NAME_LEN) ?
                                        NAME_B[(k >= NAME_POS && k < NAME_POS + NAME_LEN)
                                               ? k - NAME_POS : 0] : 8'h00;
            gifs_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (accept),
                .clear    (s_tlast),
                .din      ((k == WIN_DEPTH - 1) ? s_tdata : full_w[k + 1]),
                .ch_a     (CA),
                .ch_b     (CB),
                .cell_out (cells[k])
            );
            assign full_w[k] = cells[k].data;
        end
    endgenerate

    assign full_w[SCAN_LEN-1] = s_tdata;

    always_comb
    begin
        name_a_hit = 1'b1;
        name_b_hit = 1'b1;
        for (int i = NAME_POS; i < NAME_POS + NAME_LEN; i++)
        begin
            name_a_hit = name_a_hit && cells[i].eq_a;
            name_b_hit = name_b_hit && cells[i].eq_b;
        end
    end

    assign gce_hit = (full_w[0] == EXT_INTRO) && (full_w[1] == GCE_LABEL)
                  && (full_w[2] == GCE_SIZE);
    assign app_hit = (full_w[0] == EXT_INTRO) && (full_w[1] == APP_LABEL)
                  && (full_w[2] == APP_SIZE) && (name_a_hit || name_b_hit)
                  && (full_w[14] == SUB_LEN) && (full_w[15] == SUB_ID);

    assign cs_ext = {4'h0, full_w[5], full_w[4]};
    assign cs_ms  = (cs_ext << 3) + (cs_ext << 1);

    always_comb
    begin
        hm_next = hm_reg;
        if (seen_reg < SEEN_HDR_END && !hdr_ok(seen_reg[2:0], s_tdata))
        begin
            hm_next = 1'b0;
        end
    end

    assign scan_en = hm_next && (seen_reg >= SEEN_SCAN);
    assign gif_now = hm_next && (seen_reg >= SEEN_GIF_MIN);

    always_comb
    begin
        delay_next = delay_reg;
        loops_next = loops_reg;
        if (scan_en && gce_hit && delay_reg == 20'd0)
        begin
            delay_next = cs_ms;
        end
        if (scan_en && app_hit)
        begin
            loops_next = {full_w[17], full_w[16]};
        end
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (seen_reg < SEEN_MAX)
        begin
            seen_next = seen_reg + 1'b1;
        end
    end

    always_comb
    begin
        mv_next = mv_reg;
        if (done)
        begin
            mv_next = 1'b1;
        end
        else if (m_tready)
        begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            hm_reg    <= 1'b1;
            delay_reg <= '0;
            loops_reg <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            mv_reg <= mv_next;
            if (done)
            begin
                seen_reg  <= '0;
                hm_reg    <= 1'b1;
                delay_reg <= '0;
                loops_reg <= '0;
            end
            else if (accept)
            begin
                seen_reg  <= seen_next;
                hm_reg    <= hm_next;
                delay_reg <= delay_next;
                loops_reg <= loops_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            gif_reg    <= gif_now;
            odelay_reg <= gif_now ? delay_next : 20'd0;
            oloops_reg <= gif_now ? loops_next : 16'd0;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = gif_reg;
    assign m_tdata  = {4'h0, oloops_reg, odelay_reg};

`ifndef SYNTHESIS
    a_not_gif_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 40'd0))
        else $error("non-GIF result carries nonzero values");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> m_tvalid)
        else $error("final byte produced no result");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_MAX)
        else $error("byte count beyond saturation");

    a_delay_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (delay_reg != 20'd0 && !done) |=> $stable(delay_reg))
        else $error("latched delay changed within a file");

    a_mid_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tlast) |=> (seen_reg != '0))
        else $error("byte count not advanced");
`endif

endmodule
`default_nettype wire

[rtl/gifs_cell.sv]
// One window byte cell: holds a byte, shifts it on, compares it to name characters.
`default_nettype none
module gifs_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                shift_en,
    input  wire logic                clear,
    input  wire logic [7:0]          din,
    input  wire logic [7:0]          ch_a,
    input  wire logic [7:0]          ch_b,
    output gifs_pkg::cell_out_t      cell_out
);
    import gifs_pkg::*;

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (shift_en)
        begin
            data_next = clear ? 8'h00 : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= 8'h00;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign cell_out.data = data_reg;
    assign cell_out.eq_a = (data_reg == ch_a);
    assign cell_out.eq_b = (data_reg == ch_b);

endmodule
`default_nettype wire
